/* rtl/core/bfha_pkg.sv */
// Shared types, codes and constants of the best-fit heap allocator.
`default_nettype none
package bfha_pkg;

  // Default heap depth in 8-byte granules.
  localparam int DEF_HEAP_GRANULES = 8192;
  // Granule offset width over the 17-bit byte space, and block size width in granules.
  localparam int GOFF_W = 14;
  localparam int SZ_W   = 13;

  // Request codes.
  localparam logic [2:0] REQ_FORMAT = 3'd0;
  localparam logic [2:0] REQ_ALLOC  = 3'd1;
  localparam logic [2:0] REQ_FREE   = 3'd2;
  localparam logic [2:0] REQ_SIZE   = 3'd3;
  localparam logic [2:0] REQ_TOTAL  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_BADPTR   = 2'd2;
  localparam logic [1:0] ST_NOTALLOC = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] req_size;
    logic [31:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_addr;
    logic [16:0] block_bytes;
    logic [16:0] used_total;
    logic [16:0] free_total;
  } res_t;

  // One block header as kept in the side store.
  typedef struct packed {
    logic            start;
    logic            used;
    logic [SZ_W-1:0] size;
  } hdr_t;

  typedef enum logic [3:0] {
    S_RST_CLR, S_IDLE, S_DISPATCH, S_FMT_CLR, S_FMT_FIN, S_A_WALK, S_A_SPLIT,
    S_A_MARK, S_P_CHK, S_F_NEXT, S_F_WB, S_F_WALK, S_F_CLRB, S_T_WALK
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_DISPATCH, CMD_CLR_STEP, CMD_FMT_FIN, CMD_A_STEP,
    CMD_A_SPLIT, CMD_A_MARK, CMD_P_CHK, CMD_F_NEXT, CMD_F_WB, CMD_F_STEP,
    CMD_F_CLRB, CMD_T_STEP
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic [2:0] req_type;
    logic       bad_size;
    logic       ptr_null;
    logic       ptr_bad;
    logic       not_alloc;
    logic       walk_end;
    logic       exact;
    logic       found;
    logic       h_zero;
    logic       prev_hit;
    logic       prev_free;
    logic       prev_stop;
    logic       clr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/bfha_dpath.sv */
// Datapath of the heap allocator: header store, walk registers and result registers.
`default_nettype none
module bfha_dpath import bfha_pkg::*; #(
  parameter int HEAP_GRANULES = DEF_HEAP_GRANULES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  input  wire req_t                 in_word,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output dp_stat_t                  stat,
  output res_t                      out_word
);

  localparam int IDX_W = (HEAP_GRANULES > 1) ? $clog2(HEAP_GRANULES) : 1;

  hdr_t mem [HEAP_GRANULES];

  logic [31:0]       cfg_base_r, act_base_r;
  logic [16:0]       cfg_bytes_r, used_r;
  logic [GOFF_W-1:0] act_gran_r;
  req_t              req_r;
  logic [GOFF_W-1:0] best_r, best_sz_r, need_r, h_r, sum_r, rd_goff_r;
  logic              found_r;
  logic [SZ_W-1:0]   bsz_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  hdr_t              rdata_r;
  logic [1:0]        res_status_r;
  logic [31:0]       res_addr_r;
  logic [16:0]       res_bb_r, res_ft_r;

  logic [16:0]       act_size;
  logic [31:0]       off32;
  logic              ptr_null, ptr_bad, bad_size, blk_ok, cand, split, merge;
  logic [GOFF_W-1:0] ptr_goff, need_g, nx_g, split_goff, fmt_g, fmt_g_sat;
  logic [SZ_W-1:0]   split_size, a_size;
  logic [31:0]       fmt_aligned;
  logic [16:0]       fmt_diff, fmt_trim;
  logic [GOFF_W-1:0] rd_goff, wr_goff;
  logic              we;
  logic [IDX_W-1:0]  wr_idx;
  hdr_t              wdata;

  // Pointer, size and walk checks.
  assign act_size   = {act_gran_r, 3'b000};
  assign off32      = req_r.req_addr - act_base_r;
  assign ptr_null   = (req_r.req_addr == 32'd0);
  assign ptr_bad    = (off32 < 32'd8) || (off32 >= {15'd0, act_size}) ||
                      (req_r.req_addr[2:0] != 3'd0);
  assign ptr_goff   = off32[16:3] - GOFF_W'(1);
  assign bad_size   = (req_r.req_size == 32'd0) || (req_r.req_size > {15'd0, act_size});
  assign need_g     = req_r.req_size[16:3] + GOFF_W'(|req_r.req_size[2:0]);
  assign blk_ok     = (rd_goff_r < act_gran_r) && rdata_r.start;
  assign nx_g       = rd_goff_r + GOFF_W'(1) + GOFF_W'(rdata_r.size);
  assign cand       = blk_ok && !rdata_r.used && (GOFF_W'(rdata_r.size) >= need_r) &&
                      (GOFF_W'(rdata_r.size) < best_sz_r);
  assign split      = (best_sz_r >= need_r + GOFF_W'(2));
  assign split_goff = best_r + GOFF_W'(1) + need_r;
  assign split_size = SZ_W'(best_sz_r - need_r - GOFF_W'(1));
  assign a_size     = split ? need_r[SZ_W-1:0] : best_sz_r[SZ_W-1:0];
  assign merge      = blk_ok && !rdata_r.used;

  // Region alignment, trimming and saturation for a format request.
  assign fmt_aligned = (cfg_base_r + 32'd7) & ~32'd7;
  assign fmt_diff    = {14'd0, 3'(3'd0 - cfg_base_r[2:0])};
  assign fmt_trim    = (fmt_diff < cfg_bytes_r) ? (cfg_bytes_r - fmt_diff) : 17'd0;
  assign fmt_g       = fmt_trim[16:3];
  assign fmt_g_sat   = ({3'd0, fmt_g} > 17'(HEAP_GRANULES)) ? GOFF_W'(HEAP_GRANULES) : fmt_g;

  // Read address and write port selection.
  always_comb begin
    rd_goff = GOFF_W'(0);
    we      = 1'b0;
    wr_goff = GOFF_W'(0);
    wdata   = '0;
    wr_idx  = IDX_W'(wr_goff);
    case (cmd)
      CMD_DISPATCH: begin
        if (req_r.req_type == REQ_FREE || req_r.req_type == REQ_SIZE) rd_goff = ptr_goff;
      end
      CMD_A_STEP, CMD_T_STEP, CMD_F_STEP, CMD_P_CHK: rd_goff = nx_g;
      default: rd_goff = GOFF_W'(0);
    endcase
    case (cmd)
      CMD_FMT_FIN: begin
        we    = (act_gran_r != GOFF_W'(0));
        wdata = '{start: 1'b1, used: 1'b0, size: SZ_W'(act_gran_r - GOFF_W'(1))};
      end
      CMD_A_SPLIT: begin
        we      = found_r && split;
        wr_goff = split_goff;
        wdata   = '{start: 1'b1, used: 1'b0, size: split_size};
      end
      CMD_A_MARK: begin
        we      = 1'b1;
        wr_goff = best_r;
        wdata   = '{start: 1'b1, used: 1'b1, size: a_size};
      end
      CMD_F_NEXT: begin
        we      = merge;
        wr_goff = rd_goff_r;
        wdata   = '{start: 1'b0, used: rdata_r.used, size: rdata_r.size};
      end
      CMD_F_WB: begin
        we      = 1'b1;
        wr_goff = h_r;
        wdata   = '{start: 1'b1, used: 1'b0, size: bsz_r};
      end
      CMD_F_STEP: begin
        we      = blk_ok && (nx_g == h_r) && !rdata_r.used;
        wr_goff = rd_goff_r;
        wdata   = '{start: 1'b1, used: 1'b0,
                    size: SZ_W'(rdata_r.size + SZ_W'(1) + bsz_r)};
      end
      CMD_F_CLRB: begin
        we      = 1'b1;
        wr_goff = h_r;
        wdata   = '{start: 1'b0, used: 1'b0, size: bsz_r};
      end
      CMD_CLR_STEP: we = 1'b1;
      default: we = 1'b0;
    endcase
    wr_idx = (cmd == CMD_CLR_STEP) ? clr_cnt_r : IDX_W'(wr_goff);
  end

  // Header store with a registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[wr_idx] <= wdata;
    rdata_r   <= mem[IDX_W'(rd_goff)];
    rd_goff_r <= rd_goff;
  end

  // Configuration, heap state and clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r  <= 32'd0;
      cfg_bytes_r <= 17'd0;
      act_base_r  <= 32'd0;
      act_gran_r  <= GOFF_W'(0);
      used_r      <= 17'd0;
      clr_cnt_r   <= IDX_W'(0);
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_HEAP_BASE) cfg_base_r <= cfg_data;
        if (cfg_index == REG_HEAP_BYTES) cfg_bytes_r <= cfg_data[16:0];
      end
      if (cmd == CMD_CLR_STEP) begin
        clr_cnt_r <= (clr_cnt_r == IDX_W'(HEAP_GRANULES - 1)) ? IDX_W'(0)
                                                                : clr_cnt_r + IDX_W'(1);
      end
      if (cmd == CMD_DISPATCH && req_r.req_type == REQ_FORMAT) begin
        used_r <= 17'd0;
        if (fmt_g_sat < GOFF_W'(2)) begin
          act_base_r <= 32'd0;
          act_gran_r <= GOFF_W'(0);
        end else begin
          act_base_r <= fmt_aligned;
          act_gran_r <= fmt_g_sat;
        end
      end
      if (cmd == CMD_A_MARK) used_r <= used_r + 17'({a_size, 3'b000}) + 17'd8;
      if (cmd == CMD_P_CHK && !(!(rdata_r.start && rdata_r.used)) &&
          req_r.req_type == REQ_FREE) begin
        used_r <= used_r - 17'({rdata_r.size, 3'b000}) - 17'd8;
      end
    end
  end

  // Request, walk and result registers.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        req_r        <= in_word;
        res_status_r <= ST_OK;
        res_addr_r   <= 32'd0;
        res_bb_r     <= 17'd0;
        res_ft_r     <= 17'd0;
      end
      CMD_DISPATCH: begin
        case (req_r.req_type)
          REQ_ALLOC: begin
            if (bad_size) res_status_r <= ST_NOFIT;
            need_r    <= need_g;
            best_sz_r <= '1;
            found_r   <= 1'b0;
          end
          REQ_FREE: begin
            if (!ptr_null && ptr_bad) res_status_r <= ST_BADPTR;
            h_r <= ptr_goff;
          end
          REQ_SIZE: begin
            if (ptr_null || ptr_bad) res_status_r <= ST_BADPTR;
            h_r <= ptr_goff;
          end
          REQ_TOTAL: sum_r <= GOFF_W'(0);
          default: sum_r <= sum_r;
        endcase
      end
      CMD_A_STEP: begin
        if (cand) begin
          best_r    <= rd_goff_r;
          best_sz_r <= GOFF_W'(rdata_r.size);
          found_r   <= 1'b1;
        end
      end
      CMD_A_SPLIT: begin
        if (!found_r) res_status_r <= ST_NOFIT;
      end
      CMD_A_MARK: begin
        res_addr_r <= act_base_r + 32'({best_r + GOFF_W'(1), 3'b000});
        res_bb_r   <= 17'({a_size, 3'b000});
      end
      CMD_P_CHK: begin
        if (!(rdata_r.start && rdata_r.used)) res_status_r <= ST_NOTALLOC;
        else if (req_r.req_type == REQ_SIZE) res_bb_r <= 17'({rdata_r.size, 3'b000});
        bsz_r <= rdata_r.size;
      end
      CMD_F_NEXT: begin
        if (merge) bsz_r <= SZ_W'(bsz_r + SZ_W'(1) + rdata_r.size);
      end
      CMD_T_STEP: begin
        if (merge) sum_r <= sum_r + GOFF_W'(rdata_r.size);
        if (!blk_ok) res_ft_r <= 17'({sum_r, 3'b000});
      end
      default: sum_r <= sum_r;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    stat.req_type  = req_r.req_type;
    stat.bad_size  = bad_size;
    stat.ptr_null  = ptr_null;
    stat.ptr_bad   = ptr_bad;
    stat.not_alloc = !(rdata_r.start && rdata_r.used);
    stat.walk_end  = !blk_ok;
    stat.exact     = cand && (GOFF_W'(rdata_r.size) == need_r);
    stat.found     = found_r;
    stat.h_zero    = (h_r == GOFF_W'(0));
    stat.prev_hit  = blk_ok && (nx_g == h_r);
    stat.prev_free = !rdata_r.used;
    stat.prev_stop = !blk_ok || (nx_g >= h_r);
    stat.clr_last  = (clr_cnt_r == IDX_W'(HEAP_GRANULES - 1));
  end

  assign out_word = '{status: res_status_r, result_addr: res_addr_r, block_bytes: res_bb_r,
                      used_total: used_r, free_total: res_ft_r};

endmodule
`default_nettype wire

/* rtl/core/bfha_ctrl.sv */
// Controller state machine of the heap allocator.
`default_nettype none
module bfha_ctrl import bfha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output logic          busy,
  output logic          out_valid,
  output cmd_t          cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and strobe registers; reset starts the store clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = CMD_NONE;
    case (state_r)
      S_RST_CLR: begin
        cmd = CMD_CLR_STEP;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd           = CMD_DISPATCH;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (stat.req_type)
          REQ_FORMAT: begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_FMT_CLR;
          end
          REQ_ALLOC: begin
            if (!stat.bad_size) begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_A_WALK;
            end
          end
          REQ_FREE, REQ_SIZE: begin
            if (!stat.ptr_null && !stat.ptr_bad) begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_P_CHK;
            end
          end
          REQ_TOTAL: begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_T_WALK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FMT_CLR: begin
        cmd = CMD_CLR_STEP;
        if (stat.clr_last) state_nxt = S_FMT_FIN;
      end
      S_FMT_FIN: begin
        cmd           = CMD_FMT_FIN;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_A_WALK: begin
        cmd = CMD_A_STEP;
        if (stat.walk_end || stat.exact) state_nxt = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        cmd = CMD_A_SPLIT;
        if (stat.found) begin
          state_nxt = S_A_MARK;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_A_MARK: begin
        cmd           = CMD_A_MARK;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_P_CHK: begin
        cmd = CMD_P_CHK;
        if (stat.not_alloc || stat.req_type == REQ_SIZE) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_F_NEXT;
        end
      end
      S_F_NEXT: begin
        cmd       = CMD_F_NEXT;
        state_nxt = S_F_WB;
      end
      S_F_WB: begin
        cmd = CMD_F_WB;
        if (stat.h_zero) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_F_WALK;
        end
      end
      S_F_WALK: begin
        cmd = CMD_F_STEP;
        if (stat.prev_stop) begin
          if (stat.prev_hit && stat.prev_free) begin
            state_nxt = S_F_CLRB;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_F_CLRB: begin
        cmd           = CMD_F_CLRB;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_T_WALK: begin
        cmd = CMD_T_STEP;
        if (stat.walk_end) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* rtl/core/best_fit_heap_allocator_core.sv */
// Top level of the best-fit heap allocator with coalescing.
// A request word is taken when start is high and busy is low; its result word
// appears for one cycle with out_valid and cannot be held off. Timing follows
// the header chain, which the datapath walks one block per cycle through the
// registered read port of the header store. An allocate walks the whole chain,
// or stops at an exact fit; a free walks the blocks before the freed one; a
// free-total query walks the whole chain; a size query reads only the header
// of its block, and a rejected size or pointer is answered without a walk. A
// format runs a sweep that clears one header per cycle, and after reset the
// same sweep runs with busy high before the first request is taken;
// configuration writes are taken at any time and act at the next format.
`default_nettype none
module best_fit_heap_allocator_core import bfha_pkg::*; #(
  parameter int HEAP_GRANULES = DEF_HEAP_GRANULES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire req_t                 in_word,
  output logic                      out_valid,
  output res_t                      out_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  cmd_t     cmd;
  dp_stat_t stat;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  bfha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bfha_dpath #(.HEAP_GRANULES(HEAP_GRANULES)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

/* rtl/core/bfha_checker.sv */
// Port-level assertions of the heap allocator, bound to the top level.
`default_nettype none
module bfha_props import bfha_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire res_t out_word
);

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy low after accepted word");

  // Results are strobed for single cycles only.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");

  // A result comes out only once the block is free again.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  // A failed allocate returns no address.
  a_nofit_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == ST_NOFIT) |-> (out_word.result_addr == 32'd0))
    else $error("address returned with no-fit status");

  // A granted block always has data bytes.
  a_grant_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.result_addr != 32'd0) |-> (out_word.block_bytes != 17'd0))
    else $error("granted block without size");

endmodule

bind best_fit_heap_allocator_core bfha_props u_bfha_props (.*);
`default_nettype wire
